FILE: rtl/core/tlvrv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvrv_pkg
// shared types and codes for the tlv rule verdict engine
// ----------------------------------------------------------------------------
package tlvrv_pkg;

  // request selector on the input channel
  localparam logic [1:0] REQ_FEATURE = 2'd0;
  localparam logic [1:0] REQ_RULE    = 2'd1;
  localparam logic [1:0] REQ_END     = 2'd2;

  // classified beat kinds carried through the queue
  localparam logic [1:0] KIND_FEAT       = 2'd0;
  localparam logic [1:0] KIND_RULE_FIRST = 2'd1;
  localparam logic [1:0] KIND_RULE       = 2'd2;
  localparam logic [1:0] KIND_END        = 2'd3;

  // element parse phases
  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  // verdict codes
  localparam logic [1:0] V_ACCEPT = 2'd0;
  localparam logic [1:0] V_REJECT = 2'd1;
  localparam logic [1:0] V_QUEUE  = 2'd2;

  // feature tags
  localparam logic [7:0] TAG_FEE     = 8'h01;
  localparam logic [7:0] TAG_REPLACE = 8'h05;
  localparam logic [7:0] TAG_SCRIPT  = 8'h06;
  localparam logic [7:0] TAG_DUST    = 8'h07;

  // rule opcodes
  localparam logic [7:0] OP_MIN_FEE     = 8'h10;
  localparam logic [7:0] OP_REPLACE_FEE = 8'h11;
  localparam logic [7:0] OP_DUST_MAX    = 8'h12;
  localparam logic [7:0] OP_SCRIPT_MASK = 8'h13;
  localparam logic [7:0] OP_QUEUE_BAND  = 8'h20;

  // value byte count saturates here, enough for both operands
  localparam logic [4:0] SEEN_MAX = 5'd16;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/tlvrv_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvrv_front
// accepts input beats, drops dead ones and tags the first rule byte
// ----------------------------------------------------------------------------
module tlvrv_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [1:0]        req_type,
  input  wire logic [7:0]        data_byte,
  output logic                   push,
  output tlvrv_pkg::entry_t      push_entry,
  input  wire logic              space
);

  logic in_rules;
  logic in_rules_next;
  logic keep;
  logic accept;

  assign item_ready = space;
  assign accept     = item_valid && space;
  assign push       = accept && keep;

  always_comb begin
    keep            = 1'b0;
    in_rules_next   = in_rules;
    push_entry.kind = tlvrv_pkg::KIND_FEAT;
    push_entry.data = data_byte;
    case (req_type)
      tlvrv_pkg::REQ_FEATURE: begin
        keep = !in_rules;
      end
      tlvrv_pkg::REQ_RULE: begin
        keep            = 1'b1;
        push_entry.kind = in_rules ? tlvrv_pkg::KIND_RULE : tlvrv_pkg::KIND_RULE_FIRST;
        in_rules_next   = 1'b1;
      end
      tlvrv_pkg::REQ_END: begin
        keep            = 1'b1;
        push_entry.kind = tlvrv_pkg::KIND_END;
        in_rules_next   = 1'b0;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_rules <= 1'b0;
    end else if (accept) begin
      in_rules <= in_rules_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlvrv_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvrv_queue
// small register fifo between the front and the back
// ----------------------------------------------------------------------------
module tlvrv_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire tlvrv_pkg::entry_t push_entry,
  output logic                   space,
  input  wire logic              pop,
  output logic                   head_valid,
  output tlvrv_pkg::entry_t      head_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  tlvrv_pkg::entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign space      = (count != FULL);
  assign head_valid = (count != '0);
  assign head_entry = slots[rd_ptr];
  assign do_push    = push && space;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlvrv_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlvrv_back
// element parser, feature store, rule evaluation and verdict register
// ----------------------------------------------------------------------------
module tlvrv_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              head_valid,
  input  wire tlvrv_pkg::entry_t head_entry,
  output logic                   pop,
  output logic                   verdict_valid,
  input  wire logic              verdict_ready,
  output logic [1:0]             verdict
);

  // control state
  logic [1:0]  phase,        phase_next;
  logic        fee_known,    fee_known_next;
  logic        decided,      decided_next;
  logic [1:0]  decided_verdict, decided_verdict_next;
  logic        mask_ok,      mask_ok_next;
  logic        out_valid,    out_valid_next;
  // element and feature registers
  logic [7:0]  tag,          tag_next;
  logic [7:0]  rem_len,      rem_len_next;
  logic [4:0]  seen,         seen_next;
  logic [63:0] op_a,         op_a_next;
  logic [63:0] op_b,         op_b_next;
  logic [15:0] lead,         lead_next;
  logic [63:0] fee_rate,     fee_rate_next;
  logic [15:0] replace_flag, replace_flag_next;
  logic [15:0] script_bits,  script_bits_next;
  logic [15:0] dust_amount,  dust_amount_next;
  logic [1:0]  out_verdict,  out_verdict_next;

  logic [7:0]  b;
  logic        is_rule;
  logic [1:0]  cur_phase;
  logic [63:0] a_new;
  logic [63:0] b_new;
  logic [15:0] lead_new;
  logic [4:0]  seen_new;
  logic        has2, has8, has16;
  logic        fee_below_a;
  logic        fee_below_b;

  assign b       = head_entry.data;
  assign is_rule = (head_entry.kind == tlvrv_pkg::KIND_RULE) ||
                   (head_entry.kind == tlvrv_pkg::KIND_RULE_FIRST);
  assign pop     = head_valid &&
                   ((head_entry.kind != tlvrv_pkg::KIND_END) || !out_valid || verdict_ready);

  assign verdict_valid = out_valid;
  assign verdict       = out_verdict;

  // value byte shift-in, operands fill in stream order
  always_comb begin
    a_new    = (seen < 5'd8) ? {op_a[55:0], b} : op_a;
    b_new    = ((seen >= 5'd8) && (seen < tlvrv_pkg::SEEN_MAX)) ? {op_b[55:0], b} : op_b;
    lead_new = lead;
    if (seen == 5'd0) begin
      lead_new = {b, 8'h00};
    end else if (seen == 5'd1) begin
      lead_new = {lead[15:8], b};
    end
    seen_new = (seen == tlvrv_pkg::SEEN_MAX) ? seen : seen + 5'd1;
  end

  assign has2        = (seen_new >= 5'd2);
  assign has8        = (seen_new >= 5'd8);
  assign has16       = (seen_new == tlvrv_pkg::SEEN_MAX);
  assign fee_below_a = (fee_rate < a_new);
  assign fee_below_b = (fee_rate < b_new);

  always_comb begin
    phase_next           = phase;
    fee_known_next       = fee_known;
    decided_next         = decided;
    decided_verdict_next = decided_verdict;
    mask_ok_next         = mask_ok;
    tag_next             = tag;
    rem_len_next         = rem_len;
    seen_next            = seen;
    op_a_next            = op_a;
    op_b_next            = op_b;
    lead_next            = lead;
    fee_rate_next        = fee_rate;
    replace_flag_next    = replace_flag;
    script_bits_next     = script_bits;
    dust_amount_next     = dust_amount;
    out_verdict_next     = out_verdict;
    out_valid_next       = out_valid && !verdict_ready;
    // first rule byte drops any unfinished feature element
    cur_phase = (head_entry.kind == tlvrv_pkg::KIND_RULE_FIRST) ? tlvrv_pkg::PH_TAG : phase;

    if (pop) begin
      if (head_entry.kind == tlvrv_pkg::KIND_END) begin
        if (!fee_known) begin
          out_verdict_next = tlvrv_pkg::V_REJECT;
        end else if (decided) begin
          out_verdict_next = decided_verdict;
        end else if (!mask_ok) begin
          out_verdict_next = tlvrv_pkg::V_REJECT;
        end else begin
          out_verdict_next = tlvrv_pkg::V_ACCEPT;
        end
        out_valid_next       = 1'b1;
        // back to a clean evaluation
        phase_next           = tlvrv_pkg::PH_TAG;
        fee_known_next       = 1'b0;
        decided_next         = 1'b0;
        decided_verdict_next = tlvrv_pkg::V_ACCEPT;
        mask_ok_next         = 1'b1;
        tag_next             = '0;
        rem_len_next         = '0;
        seen_next            = '0;
        op_a_next            = '0;
        op_b_next            = '0;
        lead_next            = '0;
        fee_rate_next        = '0;
        replace_flag_next    = '0;
        script_bits_next     = '0;
        dust_amount_next     = '0;
      end else begin
        case (cur_phase)
          tlvrv_pkg::PH_TAG: begin
            tag_next   = b;
            phase_next = tlvrv_pkg::PH_LEN;
          end
          tlvrv_pkg::PH_LEN: begin
            rem_len_next = b;
            seen_next    = '0;
            op_a_next    = '0;
            op_b_next    = '0;
            lead_next    = '0;
            // zero length element finishes with nothing to apply
            phase_next   = (b == 8'h00) ? tlvrv_pkg::PH_TAG : tlvrv_pkg::PH_VAL;
          end
          tlvrv_pkg::PH_VAL: begin
            op_a_next    = a_new;
            op_b_next    = b_new;
            lead_next    = lead_new;
            seen_next    = seen_new;
            rem_len_next = rem_len - 8'd1;
            if (rem_len == 8'd1) begin
              phase_next = tlvrv_pkg::PH_TAG;
              if (!is_rule) begin
                case (tag)
                  tlvrv_pkg::TAG_FEE: begin
                    if (has8) begin
                      fee_rate_next  = a_new;
                      fee_known_next = 1'b1;
                    end
                  end
                  tlvrv_pkg::TAG_REPLACE: begin
                    if (has2) replace_flag_next = lead_new;
                  end
                  tlvrv_pkg::TAG_SCRIPT: begin
                    if (has2) script_bits_next = lead_new;
                  end
                  tlvrv_pkg::TAG_DUST: begin
                    if (has2) dust_amount_next = lead_new;
                  end
                  default: begin
                  end
                endcase
              end else if (!decided) begin
                case (tag)
                  tlvrv_pkg::OP_MIN_FEE: begin
                    if (has8 && fee_below_a) begin
                      decided_next         = 1'b1;
                      decided_verdict_next = tlvrv_pkg::V_REJECT;
                    end
                  end
                  tlvrv_pkg::OP_REPLACE_FEE: begin
                    if (has8 && (replace_flag != 16'h0000) && fee_below_a) begin
                      decided_next         = 1'b1;
                      decided_verdict_next = tlvrv_pkg::V_REJECT;
                    end
                  end
                  tlvrv_pkg::OP_DUST_MAX: begin
                    if (has2 && (dust_amount > lead_new)) begin
                      decided_next         = 1'b1;
                      decided_verdict_next = tlvrv_pkg::V_REJECT;
                    end
                  end
                  tlvrv_pkg::OP_SCRIPT_MASK: begin
                    if (has2 && (lead_new != 16'h0000) &&
                        ((lead_new & script_bits) == 16'h0000)) begin
                      mask_ok_next = 1'b0;
                    end
                  end
                  tlvrv_pkg::OP_QUEUE_BAND: begin
                    if (has16 && !fee_below_a && fee_below_b) begin
                      decided_next         = 1'b1;
                      decided_verdict_next = tlvrv_pkg::V_QUEUE;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
          end
          default: begin
            phase_next = tlvrv_pkg::PH_TAG;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= tlvrv_pkg::PH_TAG;
      fee_known       <= 1'b0;
      decided         <= 1'b0;
      decided_verdict <= tlvrv_pkg::V_ACCEPT;
      mask_ok         <= 1'b1;
      out_valid       <= 1'b0;
      replace_flag    <= '0;
      script_bits     <= '0;
      dust_amount     <= '0;
      fee_rate        <= '0;
    end else begin
      phase           <= phase_next;
      fee_known       <= fee_known_next;
      decided         <= decided_next;
      decided_verdict <= decided_verdict_next;
      mask_ok         <= mask_ok_next;
      out_valid       <= out_valid_next;
      replace_flag    <= replace_flag_next;
      script_bits     <= script_bits_next;
      dust_amount     <= dust_amount_next;
      fee_rate        <= fee_rate_next;
    end
  end

  always_ff @(posedge clk) begin
    tag         <= tag_next;
    rem_len     <= rem_len_next;
    seen        <= seen_next;
    op_a        <= op_a_next;
    op_b        <= op_b_next;
    lead        <= lead_next;
    out_verdict <= out_verdict_next;
  end

endmodule

`default_nettype wire

FILE: rtl/core/tlv_rule_verdict_engine_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlv_rule_verdict_engine_unit
// byte-serial feature record and rule list evaluator giving one verdict
// ----------------------------------------------------------------------------
// usage
//   input channel item_valid/item_ready carries one beat per byte: req_type
//   selects feature byte, rule byte or end; data_byte is the stream byte
//   output channel verdict_valid/verdict_ready carries one verdict beat for
//   each end beat (accept, reject or queue); other beats give no result
// throughput
//   one beat per cycle sustained while verdicts are taken; the back parser
//   takes each byte at the queue head and sets the rate
// verdict path
//   an accepted end beat is written into the queue, then popped by the
//   parser into the verdict register that drives verdict
// stall
//   while the verdict register is full and not taken, an end beat waits at
//   the queue head; feature and rule bytes behind it fill the queue and
//   item_ready drops only when the queue is full
// reset
//   rst clears the queue, the feature store and the rule decision; the block
//   takes beats as soon as it leaves reset
// ----------------------------------------------------------------------------
module tlv_rule_verdict_engine_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_ready,
  input  wire logic [1:0] req_type,
  input  wire logic [7:0] data_byte,
  output logic            verdict_valid,
  input  wire logic       verdict_ready,
  output logic [1:0]      verdict
);

  // front to queue
  logic              push;
  tlvrv_pkg::entry_t push_entry;
  logic              space;
  // queue to back
  logic              pop;
  logic              head_valid;
  tlvrv_pkg::entry_t head_entry;

  // classify beats, drop late feature bytes and unused selectors
  tlvrv_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .push       (push),
    .push_entry (push_entry),
    .space      (space)
  );

  // decouples input acceptance from verdict stalls
  tlvrv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .space      (space),
    .pop        (pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // parse elements, hold features, evaluate rules, register verdict
  tlvrv_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_entry    (head_entry),
    .pop           (pop),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

endmodule

`default_nettype wire

FILE: tb/sv/tlv_rule_verdict_engine_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_rule_verdict_engine_unit_tb
// drives byte beats of feature records, rule lists and end requests through
// the verdict engine and checks each verdict against the table value or a
// cycle-free model of the evaluator; a short hand-written table goes first,
// then random evaluations, with bursty input traffic and a stalling verdict
// sink
module tlv_rule_verdict_engine_unit_tb;

  // selector value the block must ignore
  localparam logic [1:0] REQ_SPARE   = 2'd3;
  localparam logic [7:0] TAG_UNKNOWN = 8'h99;

  localparam int RANDOM_BEATS  = 1650;
  localparam int IDLE_LIMIT    = 3000;
  localparam int DIRECTED_ROWS = 32;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] data;
    logic       typed;    // verdict below is known up front
    logic [1:0] verdict;
  } script_row_t;

  typedef struct {
    logic [1:0] req;
    logic [7:0] data;
    bit         typed;
    logic [1:0] verdict;
    bit         drain;    // hold this beat until no verdict is pending
  } beat_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_BURSTY
  } sink_mode_e;

  // hand-written opening: ignored selector, empty evaluation, then one
  // evaluation full of short, empty, unknown and cut-off elements
  localparam script_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{REQ_SPARE,              8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_END,     8'h00,                     1'b1, tlvrv_pkg::V_REJECT},
    '{tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_FEE,        1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'h08,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_FEATURE, 8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    // lone tag, cut by rules
    '{tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_REPLACE,    1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    tlvrv_pkg::OP_SCRIPT_MASK, 1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h02,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h00,                     1'b0, tlvrv_pkg::V_ACCEPT},
    // zero mask, no effect
    '{tlvrv_pkg::REQ_RULE,    8'h00,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    tlvrv_pkg::OP_DUST_MAX,    1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h01,                     1'b0, tlvrv_pkg::V_ACCEPT},
    // short operand
    '{tlvrv_pkg::REQ_RULE,    8'hff,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    tlvrv_pkg::OP_MIN_FEE,     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h00,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    tlvrv_pkg::OP_REPLACE_FEE, 1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h00,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    tlvrv_pkg::OP_QUEUE_BAND,  1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h00,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    TAG_UNKNOWN,               1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h01,                     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_RULE,    8'h00,                     1'b0, tlvrv_pkg::V_ACCEPT},
    // feature byte too late
    '{tlvrv_pkg::REQ_FEATURE, 8'h55,                     1'b0, tlvrv_pkg::V_ACCEPT},
    // cut by end
    '{tlvrv_pkg::REQ_RULE,    tlvrv_pkg::OP_MIN_FEE,     1'b0, tlvrv_pkg::V_ACCEPT},
    '{tlvrv_pkg::REQ_END,     8'h00,                     1'b1, tlvrv_pkg::V_ACCEPT}
  };

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       item_valid    = 1'b0;
  logic       item_ready;
  logic [1:0] req_type      = tlvrv_pkg::REQ_FEATURE;
  logic [7:0] data_byte     = 8'h00;
  logic       verdict_valid;
  logic       verdict_ready = 1'b0;
  logic [1:0] verdict;

  tlv_rule_verdict_engine_unit uut (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .req_type      (req_type),
    .data_byte     (data_byte),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  beat_t      beat_feed [$];
  logic [1:0] verdict_due [$];
  beat_t      on_wire;
  bit         drain_next  = 1'b0;
  int         error_count = 0;
  int         idle_cycles = 0;
  int         gap_left    = 0;
  int         burst_left  = 0;
  int         stall_left  = 0;
  int         mode_left   = 0;
  sink_mode_e sink_mode   = SINK_OPEN;

  // --------------------------------------------------------------------------
  // evaluator model
  // --------------------------------------------------------------------------
  typedef struct {
    logic [1:0]  phase;
    logic [7:0]  tag;
    logic [7:0]  left;
    int unsigned seen;
    logic [63:0] op_a;
    logic [63:0] op_b;
    logic [63:0] fee;
    bit          fee_ok;
    logic [15:0] repl;
    logic [15:0] script;
    logic [15:0] dust;
    bit          rules_on;
    bit          settled;
    logic [1:0]  settled_v;
    bit          mask_pass;
  } engine_t;

  engine_t eng;

  function automatic void drop_element();
    eng.phase = tlvrv_pkg::PH_TAG;
    eng.tag   = 8'h00;
    eng.left  = 8'h00;
    eng.seen  = 0;
    eng.op_a  = 64'h0;
    eng.op_b  = 64'h0;
  endfunction

  function automatic void engine_clear();
    drop_element();
    eng.fee       = 64'h0;
    eng.fee_ok    = 1'b0;
    eng.repl      = 16'h0;
    eng.script    = 16'h0;
    eng.dust      = 16'h0;
    eng.rules_on  = 1'b0;
    eng.settled   = 1'b0;
    eng.settled_v = tlvrv_pkg::V_ACCEPT;
    eng.mask_pass = 1'b1;
  endfunction

  // leading two value bytes, wherever they sit in the shift register
  function automatic logic [15:0] lead_word();
    int unsigned n;
    n = (eng.seen > 8) ? 8 : eng.seen;
    return 16'(eng.op_a >> (8 * (n - 2)));
  endfunction

  function automatic void settle(input logic [1:0] v);
    if (!eng.settled) begin
      eng.settled   = 1'b1;
      eng.settled_v = v;
    end
  endfunction

  function automatic void close_element();
    int unsigned n;
    logic [15:0] m;
    n = eng.seen;
    if (!eng.rules_on) begin
      case (eng.tag)
        tlvrv_pkg::TAG_FEE: if (n >= 8) begin
          eng.fee    = eng.op_a;
          eng.fee_ok = 1'b1;
        end
        tlvrv_pkg::TAG_REPLACE: if (n >= 2) eng.repl = lead_word();
        tlvrv_pkg::TAG_SCRIPT:  if (n >= 2) eng.script = lead_word();
        tlvrv_pkg::TAG_DUST:    if (n >= 2) eng.dust = lead_word();
        default: ;
      endcase
    end else if (!eng.settled) begin
      case (eng.tag)
        tlvrv_pkg::OP_MIN_FEE:
          if (n >= 8 && eng.fee < eng.op_a) settle(tlvrv_pkg::V_REJECT);
        tlvrv_pkg::OP_REPLACE_FEE:
          if (n >= 8 && eng.repl != 16'h0 && eng.fee < eng.op_a)
            settle(tlvrv_pkg::V_REJECT);
        tlvrv_pkg::OP_DUST_MAX:
          if (n >= 2 && eng.dust > lead_word()) settle(tlvrv_pkg::V_REJECT);
        tlvrv_pkg::OP_SCRIPT_MASK: if (n >= 2) begin
          m = lead_word();
          if (m != 16'h0 && (m & eng.script) == 16'h0) eng.mask_pass = 1'b0;
        end
        tlvrv_pkg::OP_QUEUE_BAND:
          if (n >= 16 && eng.fee >= eng.op_a && eng.fee < eng.op_b)
            settle(tlvrv_pkg::V_QUEUE);
        default: ;
      endcase
    end
    drop_element();
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    case (eng.phase)
      tlvrv_pkg::PH_TAG: begin
        eng.tag   = b;
        eng.phase = tlvrv_pkg::PH_LEN;
      end
      tlvrv_pkg::PH_LEN: begin
        eng.left = b;
        eng.seen = 0;
        eng.op_a = 64'h0;
        eng.op_b = 64'h0;
        if (b == 8'h00) close_element();
        else eng.phase = tlvrv_pkg::PH_VAL;
      end
      default: begin
        if (eng.seen < 8) eng.op_a = {eng.op_a[55:0], b};
        else if (eng.seen < 16) eng.op_b = {eng.op_b[55:0], b};
        if (eng.seen < 255) eng.seen++;
        eng.left--;
        if (eng.left == 8'h00) close_element();
      end
    endcase
  endfunction

  // advances the model by one accepted beat; returns 1 when it gives a verdict
  function automatic bit verdict_for_beat(input logic [1:0] req, input logic [7:0] b,
                                          output logic [1:0] v);
    bit gives;
    gives = 1'b0;
    v     = tlvrv_pkg::V_ACCEPT;
    case (req)
      tlvrv_pkg::REQ_FEATURE: if (!eng.rules_on) parse_byte(b);
      tlvrv_pkg::REQ_RULE: begin
        if (!eng.rules_on) begin
          drop_element();
          eng.rules_on = 1'b1;
        end
        parse_byte(b);
      end
      tlvrv_pkg::REQ_END: begin
        if (!eng.fee_ok) v = tlvrv_pkg::V_REJECT;
        else if (eng.settled) v = eng.settled_v;
        else if (!eng.mask_pass) v = tlvrv_pkg::V_REJECT;
        else v = tlvrv_pkg::V_ACCEPT;
        engine_clear();
        gives = 1'b1;
      end
      default: ;
    endcase
    return gives;
  endfunction

  // --------------------------------------------------------------------------
  // random evaluations
  // --------------------------------------------------------------------------
  task automatic put_beat(input logic [1:0] req, input logic [7:0] data);
    beat_t b;
    b.req     = req;
    b.data    = data;
    b.typed   = 1'b0;
    b.verdict = tlvrv_pkg::V_ACCEPT;
    b.drain   = drain_next;
    drain_next = 1'b0;
    beat_feed.push_back(b);
  endtask

  // tag, length, then value bytes taken from the top of val; cut >= 0 stops
  // the element after that many beats
  task automatic put_element(input logic [1:0] req, input logic [7:0] tag, input int len,
                             input logic [127:0] val, input int cut);
    int total;
    total = len + 2;
    if (cut >= 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i == 0) put_beat(req, tag);
      else if (i == 1) put_beat(req, 8'(len));
      else if (i - 2 < 16) put_beat(req, val[127 - 8 * (i - 2) -: 8]);
      else put_beat(req, 8'($urandom));
    end
  endtask

  // mostly the exact operand size, sometimes short or long, rarely huge
  function automatic int pick_len(input int exact);
    int r;
    r = $urandom_range(0, 59);
    if (r == 0) return $urandom_range(100, 255);
    if (r < 12) return $urandom_range(0, 24);
    return exact;
  endfunction

  function automatic logic [63:0] pick_wide();
    case ($urandom_range(0, 5))
      0:       return 64'h0;
      1:       return '1;
      2:       return 64'($urandom_range(0, 300));
      3:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // thresholds right at, just above or just below the fee rate, or a random wide value
  function automatic logic [63:0] near_wide(input logic [63:0] base);
    case ($urandom_range(0, 3))
      0:       return base;
      1:       return base + 64'h1;
      2:       return base - 64'h1;
      default: return pick_wide();
    endcase
  endfunction

  function automatic logic [15:0] near_half(input logic [15:0] base);
    case ($urandom_range(0, 5))
      0:       return base;
      1:       return base + 16'h1;
      2:       return base - 16'h1;
      3:       return 16'h0;
      4:       return '1;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_mask(input logic [15:0] bits);
    case ($urandom_range(0, 3))
      0:       return 16'h0;
      1:       return ~bits;
      2:       return bits;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_evaluation();
    logic [63:0] fee_g;
    logic [15:0] script_g;
    logic [15:0] dust_g;
    logic [15:0] repl_g;
    int          n;
    fee_g    = pick_wide();
    script_g = 16'($urandom);
    dust_g   = near_half(16'($urandom));
    if ($urandom_range(0, 11) == 0) drain_next = 1'b1;

    // noise: random selectors and bytes, then an end
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 14);
      repeat (n) put_beat(2'($urandom), 8'($urandom));
      put_beat(tlvrv_pkg::REQ_END, 8'($urandom));
      return;
    end

    // feature record
    if ($urandom_range(0, 7) != 0)
      put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_FEE, pick_len(8),
                  {fee_g, 64'h0}, -1);
    n = $urandom_range(0, 4);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          fee_g = pick_wide();
          put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_FEE, pick_len(8),
                      {fee_g, 64'h0}, -1);
        end
        1: begin
          repl_g = ($urandom_range(0, 1) != 0) ? 16'h0 : 16'($urandom);
          put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_REPLACE, pick_len(2),
                      {repl_g, 112'h0}, -1);
        end
        2: put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_SCRIPT, pick_len(2),
                       {script_g, 112'h0}, -1);
        3: put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_DUST, pick_len(2),
                       {dust_g, 112'h0}, -1);
        4: put_element(tlvrv_pkg::REQ_FEATURE, 8'($urandom), $urandom_range(0, 12),
                       {$urandom, $urandom, $urandom, $urandom}, -1);
        default: put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_REPLACE, 2,
                             {16'h1, 112'h0}, -1);
      endcase
    end
    // element cut off short, before the rule list
    if ($urandom_range(0, 5) == 0)
      put_element(tlvrv_pkg::REQ_FEATURE, tlvrv_pkg::TAG_FEE, 8, {pick_wide(), 64'h0},
                  $urandom_range(1, 9));

    // rule list
    n = $urandom_range(0, 5);
    repeat (n) begin
      case ($urandom_range(0, 6))
        0: put_element(tlvrv_pkg::REQ_RULE, tlvrv_pkg::OP_MIN_FEE, pick_len(8),
                       {near_wide(fee_g), 64'h0}, -1);
        1: put_element(tlvrv_pkg::REQ_RULE, tlvrv_pkg::OP_REPLACE_FEE, pick_len(8),
                       {near_wide(fee_g), 64'h0}, -1);
        2: put_element(tlvrv_pkg::REQ_RULE, tlvrv_pkg::OP_DUST_MAX, pick_len(2),
                       {near_half(dust_g), 112'h0}, -1);
        3: put_element(tlvrv_pkg::REQ_RULE, tlvrv_pkg::OP_SCRIPT_MASK, pick_len(2),
                       {pick_mask(script_g), 112'h0}, -1);
        4: put_element(tlvrv_pkg::REQ_RULE, tlvrv_pkg::OP_QUEUE_BAND, pick_len(16),
                       {near_wide(fee_g), near_wide(fee_g)}, -1);
        5: put_element(tlvrv_pkg::REQ_RULE, 8'($urandom), $urandom_range(0, 10),
                       {$urandom, $urandom, $urandom, $urandom}, -1);
        default: put_beat(tlvrv_pkg::REQ_FEATURE, 8'($urandom));
      endcase
    end
    // element cut off by the end
    if ($urandom_range(0, 5) == 0)
      put_element(tlvrv_pkg::REQ_RULE, tlvrv_pkg::OP_QUEUE_BAND, 16,
                  {near_wide(fee_g), pick_wide()}, $urandom_range(1, 17));
    put_beat(tlvrv_pkg::REQ_END, 8'($urandom));
  endtask

  task automatic report_mismatch(input string what, input logic [1:0] want,
                                 input logic [1:0] got);
    error_count++;
    if (error_count <= 10)
      $display("%0t  %s: expected verdict %0d, got %0d", $time, what, want, got);
  endtask

  // --------------------------------------------------------------------------
  // per-cycle traffic: verdict check, input beat accounting, both sides' idling
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : beat_engine
    logic       take_in;
    logic       take_out;
    logic       nxt_valid;
    logic       nxt_ready;
    logic       gives;
    logic [1:0] want;
    logic [1:0] predicted;
    take_in  = item_valid && item_ready;
    take_out = verdict_valid && verdict_ready;
    if (rst) begin
      item_valid    <= 1'b0;
      verdict_ready <= 1'b0;
    end else begin
      if (take_out) begin
        if (verdict_due.size() == 0) begin
          report_mismatch("verdict with none pending", 2'bxx, verdict);
        end else begin
          want = verdict_due.pop_front();
          if (verdict !== want) report_mismatch("verdict", want, verdict);
        end
      end
      if (take_in) begin
        gives = verdict_for_beat(on_wire.req, on_wire.data, predicted);
        if (gives) verdict_due.push_back(on_wire.typed ? on_wire.verdict : predicted);
      end
      idle_cycles = (take_in || take_out) ? 0 : idle_cycles + 1;

      // sender: bursts and gaps, a held beat keeps valid and payload
      nxt_valid = item_valid && !take_in;
      if (!nxt_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (beat_feed.size() != 0 &&
                     (!beat_feed[0].drain || verdict_due.size() == 0)) begin
          on_wire   = beat_feed.pop_front();
          nxt_valid = 1'b1;
          req_type  <= on_wire.req;
          data_byte <= on_wire.data;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 32);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      item_valid <= nxt_valid;

      // sink: open, coin flip, or long stalls, in randomly chosen modes
      if (mode_left == 0) begin
        sink_mode = sink_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(40, 400);
      end else begin
        mode_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else begin
        case (sink_mode)
          SINK_OPEN: nxt_ready = 1'b1;
          SINK_COIN: nxt_ready = ($urandom_range(0, 2) != 0);
          default: begin
            nxt_ready = 1'b1;
            if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 30);
          end
        endcase
      end
      verdict_ready <= nxt_ready;
    end
  end

  // watchdog: too long with no beat on either channel
  initial begin : watchdog
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : run_control
    beat_t row;
    engine_clear();
    foreach (DIRECTED[i]) begin
      row.req     = DIRECTED[i].req;
      row.data    = DIRECTED[i].data;
      row.typed   = DIRECTED[i].typed;
      row.verdict = DIRECTED[i].verdict;
      row.drain   = 1'b0;
      beat_feed.push_back(row);
    end
    // random part opens with a pause until the directed verdicts are back
    drain_next = 1'b1;
    while (beat_feed.size() < DIRECTED_ROWS + RANDOM_BEATS) add_evaluation();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (beat_feed.size() != 0 || item_valid || verdict_due.size() != 0);
    repeat (8) @(posedge clk);

    if (error_count == 0 && verdict_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: tlv_rule_verdict_engine_unit.f
rtl/core/tlvrv_pkg.sv
rtl/core/tlvrv_front.sv
rtl/core/tlvrv_queue.sv
rtl/core/tlvrv_back.sv
rtl/core/tlv_rule_verdict_engine_unit.sv
tb/sv/tlv_rule_verdict_engine_unit_tb.sv
